// File: rtl/blp_pkg.sv
// Shared types, register codes, reset values and helpers for the ballistic landing predictor.
// Used by the top level and the testbench; the cell modules are self-contained.
package blp_pkg;

   localparam int FRAC_BITS_DEF = 16;

   localparam logic [1:0] CSR_GRAVITY  = 2'd0;
   localparam logic [1:0] CSR_COURT    = 2'd1;
   localparam logic [1:0] CSR_MAX_TIME = 2'd2;
   localparam logic [1:0] CSR_MIN_CONF = 2'd3;

   localparam logic [30:0] GRAVITY_RST  = 31'd642252;
   localparam logic [31:0] COURT_RST    = 32'd0;
   localparam logic [30:0] MAX_TIME_RST = 31'd196608;
   localparam logic [16:0] MIN_CONF_RST = 17'd0;

   localparam logic [16:0] CONF_ONE  = 17'd65536;
   localparam logic [30:0] SIGMA_MAX = 31'h7fffffff;

   // Input word, first field in the lowest bits.
   typedef struct packed {
      logic signed [31:0] var_vel_z;
      logic signed [31:0] var_pos_z;
      logic signed [31:0] var_vel_x;
      logic signed [31:0] var_pos_x;
      logic signed [31:0] vel_z;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] pos_z;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_x;
   } blp_req_type;

   // Result word, first field in the lowest bits.
   typedef struct packed {
      logic [1:0]         pad;
      logic [16:0]        confidence;
      logic [30:0]        sigma_z;
      logic [30:0]        sigma_x;
      logic [30:0]        time_to_land;
      logic signed [31:0] land_z;
      logic signed [31:0] land_x;
   } blp_rsp_type;

   // Data riding beside the landing-time root.
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_z;
      logic signed [31:0] var_pos_x;
      logic signed [31:0] var_vel_x;
      logic signed [31:0] var_pos_z;
      logic signed [31:0] var_vel_z;
      logic signed [31:0] vel_y;
      logic               above;
      logic               reject;
   } blp_rside_type;

   // Data riding beside the landing-time divider.
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_z;
      logic signed [31:0] var_pos_x;
      logic signed [31:0] var_vel_x;
      logic signed [31:0] var_pos_z;
      logic signed [31:0] var_vel_z;
      logic               above;
      logic               reject;
   } blp_dside_type;

   // Data riding beside the x sigma root.
   typedef struct packed {
      logic signed [31:0] land_x;
      logic [30:0]        t;
      logic               above;
      logic               reject;
   } blp_xside_type;

   // Data riding beside the confidence divider.
   typedef struct packed {
      logic signed [31:0] land_x;
      logic signed [31:0] land_z;
      logic [30:0]        t;
      logic [30:0]        sx;
      logic [30:0]        sz;
      logic               above;
      logic               reject;
   } blp_cside_type;

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > 64'sh000000007fffffff) begin
         r = 32'h7fffffff;
      end else if (v < -64'sh0000000080000000) begin
         r = 32'h80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/blp_root_cell.sv
// One step of a restoring square root: takes two radicand bits, yields one root bit.
// Stand-alone cell; chained by the top level. No package dependency.
module blp_root_cell #(
   parameter int N_W = 66,
   parameter int Q_W = 33,
   parameter int S_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [N_W-1:0]   in_rad,
   input  logic [Q_W+1:0]   in_rem,
   input  logic [Q_W-1:0]   in_root,
   input  logic [S_W-1:0]   in_side,
   output logic             out_valid,
   output logic [N_W-1:0]   out_rad,
   output logic [Q_W+1:0]   out_rem,
   output logic [Q_W-1:0]   out_root,
   output logic [S_W-1:0]   out_side
);

   logic [Q_W+3:0] rem_sh;
   logic [Q_W+3:0] trial;
   logic           take;
   logic [Q_W+3:0] diff;

   logic             valid_ff;
   logic [N_W-1:0]   rad_ff;
   logic [Q_W+1:0]   rem_ff;
   logic [Q_W-1:0]   root_ff;
   logic [S_W-1:0]   side_ff;

   assign rem_sh = {in_rem, in_rad[N_W-1 -: 2]};
   assign trial  = {2'b00, in_root, 2'b01};
   assign take   = rem_sh >= trial;
   assign diff   = rem_sh - trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= {in_rad[N_W-3:0], 2'b00};
         rem_ff  <= take ? diff[Q_W+1:0] : rem_sh[Q_W+1:0];
         root_ff <= {in_root[Q_W-2:0], take};
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;

endmodule

// File: rtl/blp_div_cell.sv
// One step of a restoring divider: shifts in one dividend bit, yields one quotient bit.
// Stand-alone cell; chained by the top level. No package dependency.
module blp_div_cell #(
   parameter int D_W = 31,
   parameter int N_W = 31,
   parameter int Q_W = 31,
   parameter int S_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [D_W-1:0]   in_div,
   input  logic [D_W-1:0]   in_rem,
   input  logic [N_W-1:0]   in_num,
   input  logic [Q_W-1:0]   in_q,
   input  logic [S_W-1:0]   in_side,
   output logic             out_valid,
   output logic [D_W-1:0]   out_div,
   output logic [D_W-1:0]   out_rem,
   output logic [N_W-1:0]   out_num,
   output logic [Q_W-1:0]   out_q,
   output logic [S_W-1:0]   out_side
);

   logic [D_W:0] rem_sh;
   logic         take;
   logic [D_W:0] diff;

   logic             valid_ff;
   logic [D_W-1:0]   div_ff;
   logic [D_W-1:0]   rem_ff;
   logic [N_W-1:0]   num_ff;
   logic [Q_W-1:0]   q_ff;
   logic [S_W-1:0]   side_ff;

   assign rem_sh = {in_rem, in_num[N_W-1]};
   assign take   = rem_sh >= {1'b0, in_div};
   assign diff   = rem_sh - {1'b0, in_div};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff  <= in_div;
         rem_ff  <= take ? diff[D_W-1:0] : rem_sh[D_W-1:0];
         num_ff  <= {in_num[N_W-2:0], 1'b0};
         q_ff    <= {in_q[Q_W-2:0], take};
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;
   assign out_rem   = rem_ff;
   assign out_num   = num_ff;
   assign out_q     = q_ff;
   assign out_side  = side_ff;

endmodule

// File: rtl/ballistic_landing_predictor.sv
// Ballistic landing predictor top level: pipeline stages around chains of root and divide cells.
// Depends on blp_pkg, blp_root_cell and blp_div_cell.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_tvalid/req_tready  | req_tdata: ten 32-bit track fields
//  rsp     | out       | rsp_tvalid/rsp_tready  | rsp_tdata: landing fields, rsp_tuser: valid_res
//  csr     | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// One word is accepted per cycle while the pipe advances; each word reaches rsp through
// 128 register stages: the 33-cell landing-time root, 31-cell divider, 32-cell sigma
// roots, 17-cell confidence divider and 15 surrounding stages. The whole pipe advances together
// whenever the output register is empty or being taken, so rsp_tready stalls every stage at once.
// Reset is synchronous and clears the stage valid bits and loads the register defaults.
module ballistic_landing_predictor #(
   parameter int FRAC_BITS = blp_pkg::FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, var_pos_x, var_vel_x, var_pos_z, var_vel_z
   input  logic [319:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // land_x, land_z, time_to_land, sigma_x, sigma_z, confidence, two zero bits
   output logic [175:0] rsp_tdata,
   // valid_res
   output logic         rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);

   localparam int F       = FRAC_BITS;
   localparam int ROOT_N  = 33;
   localparam int RAD_W   = 2 * ROOT_N;
   localparam int NUM_W   = 34;
   localparam int NSH_W   = NUM_W + F;
   localparam int TDIV_N  = 31;
   localparam int T2_W    = 62 - F;
   localparam int TL_W    = (T2_W + 1) / 2;
   localparam int TH_W    = T2_W - TL_W;
   localparam int FULL_W  = T2_W + 32;
   localparam int SIG_N   = 32;
   localparam int CONF_N  = 17;
   localparam logic [63:0]       CAP       = 64'd1 << (62 - F);
   localparam logic [FULL_W-1:0] RND       = (FULL_W'(1) << F) - FULL_W'(1);
   localparam logic [FULL_W-1:0] BIG_LIM   = FULL_W'(1) << 62;
   localparam logic [63:0]       ONE       = 64'd1 << (2 * F);
   localparam logic [63:0]       ONE_HALF  = 64'd1 << (2 * F - 1);

   logic pipe_en;

   // ---------------- configuration registers
   logic [30:0]        gravity_ff;
   logic signed [31:0] court_ff;
   logic [30:0]        max_time_ff;
   logic [16:0]        min_conf_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff  <= blp_pkg::GRAVITY_RST;
         court_ff    <= blp_pkg::COURT_RST;
         max_time_ff <= blp_pkg::MAX_TIME_RST;
         min_conf_ff <= blp_pkg::MIN_CONF_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            blp_pkg::CSR_GRAVITY:  gravity_ff  <= csr_data[30:0];
            blp_pkg::CSR_COURT:    court_ff    <= csr_data;
            blp_pkg::CSR_MAX_TIME: max_time_ff <= csr_data[30:0];
            blp_pkg::CSR_MIN_CONF: min_conf_ff <= csr_data[16:0];
            default:               gravity_ff  <= gravity_ff;
         endcase
      end
   end

   // ---------------- stage A: input register
   logic                 a_valid_ff;
   blp_pkg::blp_req_type a_req_ff;

   assign req_tready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         a_req_ff <= blp_pkg::blp_req_type'(req_tdata);
      end
   end

   // ---------------- stage B: squares and gravity product
   logic [32:0]            a_dy;
   logic [31:0]            a_vy_mag;
   logic                   b_valid_ff;
   logic [63:0]            b_sq_ff;
   logic [63:0]            b_gdy_ff;
   blp_pkg::blp_rside_type b_side_ff;

   assign a_dy     = {court_ff[31], court_ff} - {a_req_ff.pos_y[31], a_req_ff.pos_y};
   assign a_vy_mag = a_req_ff.vel_y[31] ? 32'(-a_req_ff.vel_y) : a_req_ff.vel_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         b_sq_ff            <= {32'd0, a_vy_mag} * {32'd0, a_vy_mag};
         b_gdy_ff           <= {33'd0, gravity_ff} * {31'd0, a_dy};
         b_side_ff.pos_x     <= a_req_ff.pos_x;
         b_side_ff.pos_z     <= a_req_ff.pos_z;
         b_side_ff.vel_x     <= a_req_ff.vel_x;
         b_side_ff.vel_z     <= a_req_ff.vel_z;
         b_side_ff.var_pos_x <= a_req_ff.var_pos_x;
         b_side_ff.var_vel_x <= a_req_ff.var_vel_x;
         b_side_ff.var_pos_z <= a_req_ff.var_pos_z;
         b_side_ff.var_vel_z <= a_req_ff.var_vel_z;
         b_side_ff.vel_y     <= a_req_ff.vel_y;
         b_side_ff.above     <= a_req_ff.pos_y >= court_ff;
         b_side_ff.reject    <= gravity_ff == 31'd0;
      end
   end

   // ---------------- stage C: discriminant
   logic                   c_valid_ff;
   logic [RAD_W-1:0]       c_rad_ff;
   blp_pkg::blp_rside_type c_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   // The sum can carry into bit 64, which the root still sees.
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         c_rad_ff  <= {2'b00, b_sq_ff} + {1'b0, b_gdy_ff, 1'b0};
         c_side_ff <= b_side_ff;
      end
   end

   // ---------------- discriminant root chain
   logic                   r_valid [ROOT_N+1];
   logic [RAD_W-1:0]       r_rad   [ROOT_N+1];
   logic [ROOT_N+1:0]      r_rem   [ROOT_N+1];
   logic [ROOT_N-1:0]      r_root  [ROOT_N+1];
   blp_pkg::blp_rside_type r_side  [ROOT_N+1];

   assign r_valid[0] = c_valid_ff;
   assign r_rad[0]   = c_rad_ff;
   assign r_rem[0]   = '0;
   assign r_root[0]  = '0;
   assign r_side[0]  = c_side_ff;

   for (genvar i = 0; i < ROOT_N; i++) begin : g_root
      blp_root_cell #(
         .N_W (RAD_W),
         .Q_W (ROOT_N),
         .S_W ($bits(blp_pkg::blp_rside_type))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (pipe_en),
         .in_valid  (r_valid[i]),
         .in_rad    (r_rad[i]),
         .in_rem    (r_rem[i]),
         .in_root   (r_root[i]),
         .in_side   (r_side[i]),
         .out_valid (r_valid[i+1]),
         .out_rad   (r_rad[i+1]),
         .out_rem   (r_rem[i+1]),
         .out_root  (r_root[i+1]),
         .out_side  (r_side[i+1])
      );
   end

   // ---------------- stage E: numerator s - vel_y
   logic                   e_valid_ff;
   logic [NUM_W-1:0]       e_num_ff;
   blp_pkg::blp_dside_type e_side_ff;
   logic [NUM_W:0]         r_num;

   assign r_num = {2'b00, r_root[ROOT_N]}
                - {{3{r_side[ROOT_N].vel_y[31]}}, r_side[ROOT_N].vel_y};

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         e_valid_ff <= r_valid[ROOT_N];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         e_num_ff            <= r_num[NUM_W-1:0];
         e_side_ff.pos_x     <= r_side[ROOT_N].pos_x;
         e_side_ff.pos_z     <= r_side[ROOT_N].pos_z;
         e_side_ff.vel_x     <= r_side[ROOT_N].vel_x;
         e_side_ff.vel_z     <= r_side[ROOT_N].vel_z;
         e_side_ff.var_pos_x <= r_side[ROOT_N].var_pos_x;
         e_side_ff.var_vel_x <= r_side[ROOT_N].var_vel_x;
         e_side_ff.var_pos_z <= r_side[ROOT_N].var_pos_z;
         e_side_ff.var_vel_z <= r_side[ROOT_N].var_vel_z;
         e_side_ff.above     <= r_side[ROOT_N].above;
         e_side_ff.reject    <= r_side[ROOT_N].reject;
      end
   end

   // ---------------- stage F: divider setup and time overflow check
   logic [NSH_W-1:0]       e_nsh;
   logic                   e_ovf;
   logic                   f_valid_ff;
   logic [30:0]            f_rem_ff;
   logic [30:0]            f_num_ff;
   blp_pkg::blp_dside_type f_side_ff;
   blp_pkg::blp_dside_type f_side_in;

   assign e_nsh = {e_num_ff, {F{1'b0}}};
   // The quotient only fits 31 bits when the dividend is below gravity * 2^31.
   assign e_ovf = 62'(e_nsh) >= {gravity_ff, 31'd0};

   always_comb begin
      f_side_in        = e_side_ff;
      f_side_in.reject = e_side_ff.reject | e_ovf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         f_rem_ff  <= 31'(e_nsh >> 31);
         f_num_ff  <= e_nsh[30:0];
         f_side_ff <= f_side_in;
      end
   end

   // ---------------- landing time divider chain
   logic                   d_valid [TDIV_N+1];
   logic [30:0]            d_div   [TDIV_N+1];
   logic [30:0]            d_rem   [TDIV_N+1];
   logic [30:0]            d_num   [TDIV_N+1];
   logic [TDIV_N-1:0]      d_q     [TDIV_N+1];
   blp_pkg::blp_dside_type d_side  [TDIV_N+1];

   assign d_valid[0] = f_valid_ff;
   assign d_div[0]   = gravity_ff;
   assign d_rem[0]   = f_rem_ff;
   assign d_num[0]   = f_num_ff;
   assign d_q[0]     = '0;
   assign d_side[0]  = f_side_ff;

   for (genvar i = 0; i < TDIV_N; i++) begin : g_tdiv
      blp_div_cell #(
         .D_W (31),
         .N_W (31),
         .Q_W (TDIV_N),
         .S_W ($bits(blp_pkg::blp_dside_type))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (pipe_en),
         .in_valid  (d_valid[i]),
         .in_div    (d_div[i]),
         .in_rem    (d_rem[i]),
         .in_num    (d_num[i]),
         .in_q      (d_q[i]),
         .in_side   (d_side[i]),
         .out_valid (d_valid[i+1]),
         .out_div   (d_div[i+1]),
         .out_rem   (d_rem[i+1]),
         .out_num   (d_num[i+1]),
         .out_q     (d_q[i+1]),
         .out_side  (d_side[i+1])
      );
   end

   // ---------------- stage G: time products
   logic                   g_valid_ff;
   logic signed [63:0]     g_mx_ff;
   logic signed [63:0]     g_mz_ff;
   logic [61:0]            g_tt_ff;
   logic [30:0]            g_t_ff;
   blp_pkg::blp_dside_type g_side_ff;
   blp_pkg::blp_dside_type g_side_in;
   logic [30:0]            d_t;

   assign d_t = d_q[TDIV_N];

   always_comb begin
      g_side_in        = d_side[TDIV_N];
      g_side_in.reject = d_side[TDIV_N].reject | (d_t > max_time_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         g_valid_ff <= d_valid[TDIV_N];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         g_mx_ff   <= d_side[TDIV_N].vel_x * $signed({1'b0, d_t});
         g_mz_ff   <= d_side[TDIV_N].vel_z * $signed({1'b0, d_t});
         g_tt_ff   <= {31'd0, d_t} * {31'd0, d_t};
         g_t_ff    <= d_t;
         g_side_ff <= g_side_in;
      end
   end

   // ---------------- stage H: landing point, t^2, variance magnitudes
   logic                   h_valid_ff;
   logic signed [31:0]     h_land_x_ff;
   logic signed [31:0]     h_land_z_ff;
   logic [T2_W-1:0]        h_t2_ff;
   logic [30:0]            h_t_ff;
   logic                   h_above_ff;
   logic                   h_reject_ff;
   logic [31:0]            h_mag_ff  [2];
   logic                   h_neg_ff  [2];
   logic signed [31:0]     h_vpos_ff [2];
   logic signed [31:0]     g_vvel    [2];
   logic signed [31:0]     g_vpos    [2];

   assign g_vvel[0] = g_side_ff.var_vel_x;
   assign g_vvel[1] = g_side_ff.var_vel_z;
   assign g_vpos[0] = g_side_ff.var_pos_x;
   assign g_vpos[1] = g_side_ff.var_pos_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         h_valid_ff <= g_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         h_land_x_ff <= g_side_ff.above ? g_side_ff.pos_x
                      : blp_pkg::sat32(64'(g_side_ff.pos_x) + (g_mx_ff >>> F));
         h_land_z_ff <= g_side_ff.above ? g_side_ff.pos_z
                      : blp_pkg::sat32(64'(g_side_ff.pos_z) + (g_mz_ff >>> F));
         h_t2_ff     <= T2_W'(g_tt_ff >> F);
         h_t_ff      <= g_t_ff;
         h_above_ff  <= g_side_ff.above;
         h_reject_ff <= g_side_ff.reject;
         for (int l = 0; l < 2; l++) begin
            h_mag_ff[l]  <= g_vvel[l][31] ? 32'(-g_vvel[l]) : g_vvel[l];
            h_neg_ff[l]  <= g_vvel[l][31];
            h_vpos_ff[l] <= g_vpos[l];
         end
      end
   end

   // ---------------- stages I to L: propagated variance per lane (x, z)
   logic                   i_valid_ff, j_valid_ff, k_valid_ff, l_valid_ff;
   logic [TL_W+31:0]       i_pl_ff  [2];
   logic [TH_W+31:0]       i_ph_ff  [2];
   logic [FULL_W-1:0]      j_full_ff [2];
   logic signed [63:0]     k_prod_ff [2];
   logic [63:0]            l_rad_ff  [2];
   logic                   i_neg_ff [2], j_neg_ff [2];
   logic signed [31:0]     i_vpos_ff [2], j_vpos_ff [2], k_vpos_ff [2];
   logic signed [31:0]     i_lx_ff, j_lx_ff, k_lx_ff, l_lx_ff;
   logic signed [31:0]     i_lz_ff, j_lz_ff, k_lz_ff, l_lz_ff;
   logic [30:0]            i_t_ff, j_t_ff, k_t_ff, l_t_ff;
   logic                   i_ab_ff, j_ab_ff, k_ab_ff, l_ab_ff;
   logic                   i_rj_ff, j_rj_ff, k_rj_ff, l_rj_ff;
   logic signed [63:0]     k_prod_in [2];
   logic signed [63:0]     l_var     [2];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (j_full_ff[l] >= BIG_LIM) begin
            k_prod_in[l] = j_neg_ff[l] ? -$signed(CAP) : $signed(CAP);
         end else if (j_neg_ff[l]) begin
            k_prod_in[l] = -$signed(64'((j_full_ff[l] + RND) >> F));
         end else begin
            k_prod_in[l] = $signed(64'(j_full_ff[l] >> F));
         end
         l_var[l] = 64'(k_vpos_ff[l]) + k_prod_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_valid_ff <= 1'b0;
         j_valid_ff <= 1'b0;
         k_valid_ff <= 1'b0;
         l_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         i_valid_ff <= h_valid_ff;
         j_valid_ff <= i_valid_ff;
         k_valid_ff <= j_valid_ff;
         l_valid_ff <= k_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int l = 0; l < 2; l++) begin
            // t^2 is split in two halves so that each product stays near 32 x 32.
            i_pl_ff[l]   <= (TL_W+32)'(h_t2_ff[TL_W-1:0]) * (TL_W+32)'(h_mag_ff[l]);
            i_ph_ff[l]   <= (TH_W+32)'(h_t2_ff[T2_W-1:TL_W]) * (TH_W+32)'(h_mag_ff[l]);
            i_neg_ff[l]  <= h_neg_ff[l];
            i_vpos_ff[l] <= h_vpos_ff[l];
            j_full_ff[l] <= (FULL_W'(i_ph_ff[l]) << TL_W) + FULL_W'(i_pl_ff[l]);
            j_neg_ff[l]  <= i_neg_ff[l];
            j_vpos_ff[l] <= i_vpos_ff[l];
            k_prod_ff[l] <= k_prod_in[l];
            k_vpos_ff[l] <= j_vpos_ff[l];
            l_rad_ff[l]  <= (l_var[l] <= 64'sd0) ? 64'd0 : 64'(l_var[l] <<< F);
         end
         i_lx_ff <= h_land_x_ff;  j_lx_ff <= i_lx_ff;  k_lx_ff <= j_lx_ff;  l_lx_ff <= k_lx_ff;
         i_lz_ff <= h_land_z_ff;  j_lz_ff <= i_lz_ff;  k_lz_ff <= j_lz_ff;  l_lz_ff <= k_lz_ff;
         i_t_ff  <= h_t_ff;       j_t_ff  <= i_t_ff;   k_t_ff  <= j_t_ff;   l_t_ff  <= k_t_ff;
         i_ab_ff <= h_above_ff;   j_ab_ff <= i_ab_ff;  k_ab_ff <= j_ab_ff;  l_ab_ff <= k_ab_ff;
         i_rj_ff <= h_reject_ff;  j_rj_ff <= i_rj_ff;  k_rj_ff <= j_rj_ff;  l_rj_ff <= k_rj_ff;
      end
   end

   // ---------------- sigma root chains
   logic                   sx_valid [SIG_N+1];
   logic [63:0]            sx_rad   [SIG_N+1];
   logic [SIG_N+1:0]       sx_rem   [SIG_N+1];
   logic [SIG_N-1:0]       sx_root  [SIG_N+1];
   blp_pkg::blp_xside_type sx_side  [SIG_N+1];
   logic                   sz_valid [SIG_N+1];
   logic [63:0]            sz_rad   [SIG_N+1];
   logic [SIG_N+1:0]       sz_rem   [SIG_N+1];
   logic [SIG_N-1:0]       sz_root  [SIG_N+1];
   logic [31:0]            sz_side  [SIG_N+1];

   assign sx_valid[0]       = l_valid_ff;
   assign sx_rad[0]         = l_rad_ff[0];
   assign sx_rem[0]         = '0;
   assign sx_root[0]        = '0;
   assign sx_side[0].land_x = l_lx_ff;
   assign sx_side[0].t      = l_t_ff;
   assign sx_side[0].above  = l_ab_ff;
   assign sx_side[0].reject = l_rj_ff;
   assign sz_valid[0]       = l_valid_ff;
   assign sz_rad[0]         = l_rad_ff[1];
   assign sz_rem[0]         = '0;
   assign sz_root[0]        = '0;
   assign sz_side[0]        = l_lz_ff;

   for (genvar i = 0; i < SIG_N; i++) begin : g_sig
      blp_root_cell #(
         .N_W (64),
         .Q_W (SIG_N),
         .S_W ($bits(blp_pkg::blp_xside_type))
      ) u_cell_x (
         .clock     (clock),
         .reset     (reset),
         .en        (pipe_en),
         .in_valid  (sx_valid[i]),
         .in_rad    (sx_rad[i]),
         .in_rem    (sx_rem[i]),
         .in_root   (sx_root[i]),
         .in_side   (sx_side[i]),
         .out_valid (sx_valid[i+1]),
         .out_rad   (sx_rad[i+1]),
         .out_rem   (sx_rem[i+1]),
         .out_root  (sx_root[i+1]),
         .out_side  (sx_side[i+1])
      );
      blp_root_cell #(
         .N_W (64),
         .Q_W (SIG_N),
         .S_W (32)
      ) u_cell_z (
         .clock     (clock),
         .reset     (reset),
         .en        (pipe_en),
         .in_valid  (sz_valid[i]),
         .in_rad    (sz_rad[i]),
         .in_rem    (sz_rem[i]),
         .in_root   (sz_root[i]),
         .in_side   (sz_side[i]),
         .out_valid (sz_valid[i+1]),
         .out_rad   (sz_rad[i+1]),
         .out_rem   (sz_rem[i+1]),
         .out_root  (sz_root[i+1]),
         .out_side  (sz_side[i+1])
      );
   end

   // ---------------- stages M to O: sigma saturation, product, denominator
   logic                   m_valid_ff, n_valid_ff, o_valid_ff;
   blp_pkg::blp_cside_type m_side_ff, n_side_ff, o_side_ff;
   logic [61:0]            n_p_ff;
   logic [63:0]            o_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         n_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         m_valid_ff <= sx_valid[SIG_N] & sz_valid[SIG_N];
         n_valid_ff <= m_valid_ff;
         o_valid_ff <= n_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         m_side_ff.land_x <= sx_side[SIG_N].land_x;
         m_side_ff.land_z <= sz_side[SIG_N];
         m_side_ff.t      <= sx_side[SIG_N].t;
         m_side_ff.above  <= sx_side[SIG_N].above;
         m_side_ff.reject <= sx_side[SIG_N].reject;
         m_side_ff.sx     <= sx_root[SIG_N][31] ? blp_pkg::SIGMA_MAX : sx_root[SIG_N][30:0];
         m_side_ff.sz     <= sz_root[SIG_N][31] ? blp_pkg::SIGMA_MAX : sz_root[SIG_N][30:0];
         n_p_ff           <= {31'd0, m_side_ff.sx} * {31'd0, m_side_ff.sz};
         n_side_ff        <= m_side_ff;
         o_den_ff         <= ONE + 64'(n_p_ff);
         o_side_ff        <= n_side_ff;
      end
   end

   // ---------------- confidence divider chain
   logic                   q_valid [CONF_N+1];
   logic [63:0]            q_div   [CONF_N+1];
   logic [63:0]            q_rem   [CONF_N+1];
   logic [CONF_N-1:0]      q_num   [CONF_N+1];
   logic [CONF_N-1:0]      q_q     [CONF_N+1];
   blp_pkg::blp_cside_type q_side  [CONF_N+1];

   assign q_valid[0] = o_valid_ff;
   assign q_div[0]   = o_den_ff;
   assign q_rem[0]   = ONE_HALF;
   assign q_num[0]   = '0;
   assign q_q[0]     = '0;
   assign q_side[0]  = o_side_ff;

   for (genvar i = 0; i < CONF_N; i++) begin : g_conf
      blp_div_cell #(
         .D_W (64),
         .N_W (CONF_N),
         .Q_W (CONF_N),
         .S_W ($bits(blp_pkg::blp_cside_type))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (pipe_en),
         .in_valid  (q_valid[i]),
         .in_div    (q_div[i]),
         .in_rem    (q_rem[i]),
         .in_num    (q_num[i]),
         .in_q      (q_q[i]),
         .in_side   (q_side[i]),
         .out_valid (q_valid[i+1]),
         .out_div   (q_div[i+1]),
         .out_rem   (q_rem[i+1]),
         .out_num   (q_num[i+1]),
         .out_q     (q_q[i+1]),
         .out_side  (q_side[i+1])
      );
   end

   // ---------------- output register
   logic                   out_valid_ff;
   blp_pkg::blp_rsp_type   out_word_ff;
   logic                   out_flag_ff;
   blp_pkg::blp_rsp_type   out_word_in;
   logic                   out_flag_in;
   blp_pkg::blp_cside_type q_last;

   assign q_last  = q_side[CONF_N];
   assign pipe_en = !out_valid_ff || rsp_tready;

   always_comb begin
      out_word_in     = '0;
      out_flag_in     = 1'b0;
      if (q_last.above) begin
         out_word_in.land_x     = q_last.land_x;
         out_word_in.land_z     = q_last.land_z;
         out_word_in.confidence = blp_pkg::CONF_ONE;
         out_flag_in            = 1'b1;
      end else if (!q_last.reject) begin
         out_word_in.land_x       = q_last.land_x;
         out_word_in.land_z       = q_last.land_z;
         out_word_in.time_to_land = q_last.t;
         out_word_in.sigma_x      = q_last.sx;
         out_word_in.sigma_z      = q_last.sz;
         out_word_in.confidence   = q_q[CONF_N];
         out_flag_in              = q_q[CONF_N] >= min_conf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         out_valid_ff <= q_valid[CONF_N];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         out_word_ff <= out_word_in;
         out_flag_ff <= out_flag_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_word_ff;
   assign rsp_tuser  = out_flag_ff;

endmodule
